// ===== hdl/nksl_pkg.sv =====
// shared types and constants for the nearest-k sorted list
package nksl_pkg;

  localparam int DistW     = 16;
  localparam int TagW      = 32;
  localparam int KindW     = 2;
  localparam int RidxW     = 3;
  localparam int CountOutW = 4;
  localparam int PosOutW   = 3;
  localparam int DepthDef  = 8;

  localparam logic [DistW-1:0] RadiusRst = 16'd640;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  // insert beat broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic [DistW-1:0] distance;
    logic [TagW-1:0]  tag;
  } bcast_t;

  // per-cell status back to the top level
  typedef struct packed {
    logic shift;
    logic land;
    logic le_radius;
  } cell_stat_t;

endpackage

// ===== hdl/nksl_cell.sv =====
// one compare-and-shift slot of the sorted list
module nksl_cell import nksl_pkg::*; (
  input  logic             clk_i,
  input  bcast_t           bcast_i,
  input  logic [DistW-1:0] radius_i,
  input  logic             occ_i,
  input  logic             prev_occ_i,
  input  logic             prev_shift_i,
  input  logic [DistW-1:0] prev_dist_i,
  input  logic [TagW-1:0]  prev_tag_i,
  output logic [DistW-1:0] dist_o,
  output logic [TagW-1:0]  tag_o,
  output cell_stat_t       stat_o
);

  logic [DistW-1:0] dist_q, dist_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic             shift, land;

  // strict compare keeps equal distances ahead of the new entry
  assign shift = bcast_i.ins && occ_i && (bcast_i.distance < dist_q);
  assign land  = bcast_i.ins && !prev_shift_i && (shift || (!occ_i && prev_occ_i));

  always_comb begin
    dist_d = dist_q;
    tag_d  = tag_q;
    if (prev_shift_i) begin
      dist_d = prev_dist_i;
      tag_d  = prev_tag_i;
    end else if (land) begin
      dist_d = bcast_i.distance;
      tag_d  = bcast_i.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    tag_q  <= tag_d;
  end

  assign dist_o           = dist_q;
  assign tag_o            = tag_q;
  assign stat_o.shift     = shift;
  assign stat_o.land      = land;
  assign stat_o.le_radius = occ_i && (dist_q <= radius_i);

endmodule

// ===== hdl/nearest_k_sorted_list.sv =====
// top level of the nearest-k sorted list
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_stall_o | kind, distance, tag, read_index
//  out     | source    | out_valid_o/out_stall_i | count, placed, position, read, radius count
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | radius
//
// an item updates the cell row in the cycle it is accepted; its result beat
// leaves the holding stage for the output register, so one item per cycle is sustained
// while the output is not stalled. the radius count is taken from the row after
// the update. reset empties the list and loads the default radius; slot
// contents are not cleared. a stalled output holds one beat in the output
// register and one in the holding stage before the input stalls.
module nearest_k_sorted_list import nksl_pkg::*; #(
  parameter int DEPTH = DepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KindW-1:0]     kind_i,
  input  logic [DistW-1:0]     distance_i,
  input  logic [TagW-1:0]      tag_i,
  input  logic [RidxW-1:0]     read_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CountOutW-1:0] entry_count_o,
  output logic                 placed_o,
  output logic [PosOutW-1:0]   position_o,
  output logic                 read_valid_o,
  output logic [DistW-1:0]     read_distance_o,
  output logic [TagW-1:0]      read_tag_o,
  output logic [CountOutW-1:0] within_radius_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [DistW-1:0]     cfg_radius_i
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  kind_e            kind;
  logic             in_acc, out_free;
  logic [DistW-1:0] radius_q;
  logic [CW-1:0]    count_q, count_d;
  bcast_t           bcast;

  logic [DistW-1:0] slot_dist [DEPTH];
  logic [TagW-1:0]  tag   [DEPTH];
  cell_stat_t       stat  [DEPTH];
  logic             occ   [DEPTH];

  logic             placed;
  logic [PW-1:0]    pos_enc;
  logic [CW-1:0]    within_enc;
  logic             rd_hit;
  logic [DistW-1:0] rd_dist;
  logic [TagW-1:0]  rd_tag;

  logic             pend_q;
  logic [CW-1:0]    pend_count_q;
  logic             pend_placed_q;
  logic [PW-1:0]    pend_pos_q;
  logic             pend_rvalid_q;
  logic [DistW-1:0] pend_rdist_q;
  logic [TagW-1:0]  pend_rtag_q;

  logic             out_valid_q;
  logic [CW-1:0]    out_count_q;
  logic             out_placed_q;
  logic [PW-1:0]    out_pos_q;
  logic             out_rvalid_q;
  logic [DistW-1:0] out_rdist_q;
  logic [TagW-1:0]  out_rtag_q;
  logic [CW-1:0]    out_within_q;

  logic [CW+CountOutW-1:0] count_ext, within_ext;
  logic [PW+PosOutW-1:0]   pos_ext;

  assign kind        = kind_e'(kind_i);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = pend_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_radius_i;
    end
  end

  assign bcast.ins      = in_acc && (kind == KIND_INSERT);
  assign bcast.distance = distance_i;
  assign bcast.tag      = tag_i;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_q > CW'(i));
    if (i == 0) begin : g_head
      nksl_cell u_cell (
        .clk_i        (clk_i),
        .bcast_i      (bcast),
        .radius_i     (radius_q),
        .occ_i        (occ[i]),
        .prev_occ_i   (1'b1),
        .prev_shift_i (1'b0),
        .prev_dist_i  (distance_i),
        .prev_tag_i   (tag_i),
        .dist_o       (slot_dist[i]),
        .tag_o        (tag[i]),
        .stat_o       (stat[i])
      );
    end else begin : g_body
      nksl_cell u_cell (
        .clk_i        (clk_i),
        .bcast_i      (bcast),
        .radius_i     (radius_q),
        .occ_i        (occ[i]),
        .prev_occ_i   (occ[i-1]),
        .prev_shift_i (stat[i-1].shift),
        .prev_dist_i  (slot_dist[i-1]),
        .prev_tag_i   (tag[i-1]),
        .dist_o       (slot_dist[i]),
        .tag_o        (tag[i]),
        .stat_o       (stat[i])
      );
    end
  end

  // landing slot, radius boundary and read select
  always_comb begin
    placed     = 1'b0;
    pos_enc    = '0;
    within_enc = '0;
    rd_hit     = 1'b0;
    rd_dist    = '0;
    rd_tag     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      placed  = placed | stat[i].land;
      pos_enc = pos_enc | (stat[i].land ? PW'(i) : '0);
      if (stat[i].le_radius && ((i == DEPTH - 1) || !stat[(i + 1) % DEPTH].le_radius)) begin
        within_enc = within_enc | CW'(i + 1);
      end
      if ((i < (1 << RidxW)) && (read_index_i == RidxW'(i)) && occ[i]) begin
        rd_hit  = 1'b1;
        rd_dist = slot_dist[i];
        rd_tag  = tag[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    unique case (kind)
      KIND_CLEAR:  count_d = '0;
      KIND_INSERT: count_d = (count_q < CW'(DEPTH)) ? count_q + CW'(1) : count_q;
      KIND_READ:   count_d = count_q;
      KIND_NOP:    count_d = count_q;
      default:     count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
      end
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_count_q  <= count_d;
      pend_placed_q <= bcast.ins && placed;
      pend_pos_q    <= (bcast.ins && placed) ? pos_enc : '0;
      pend_rvalid_q <= (kind == KIND_READ) && rd_hit;
      pend_rdist_q  <= ((kind == KIND_READ) && rd_hit) ? rd_dist : '0;
      pend_rtag_q   <= ((kind == KIND_READ) && rd_hit) ? rd_tag : '0;
    end
    if (pend_q && out_free) begin
      out_count_q  <= pend_count_q;
      out_placed_q <= pend_placed_q;
      out_pos_q    <= pend_pos_q;
      out_rvalid_q <= pend_rvalid_q;
      out_rdist_q  <= pend_rdist_q;
      out_rtag_q   <= pend_rtag_q;
      out_within_q <= within_enc;
    end
  end

  // narrow result fields keep their low bits
  assign count_ext  = {{CountOutW{1'b0}}, out_count_q};
  assign within_ext = {{CountOutW{1'b0}}, out_within_q};
  assign pos_ext    = {{PosOutW{1'b0}}, out_pos_q};

  assign out_valid_o           = out_valid_q;
  assign entry_count_o         = count_ext[CountOutW-1:0];
  assign placed_o              = out_placed_q;
  assign position_o            = pos_ext[PosOutW-1:0];
  assign read_valid_o          = out_rvalid_q;
  assign read_distance_o       = out_rdist_q;
  assign read_tag_o            = out_rtag_q;
  assign within_radius_count_o = within_ext[CountOutW-1:0];

endmodule

// ===== test/nksl_checker.sv =====
// checker for the nearest-k sorted list: predicts every result beat and compares it
module nksl_list_checker import nksl_pkg::*; #(
  parameter int DEPTH = DepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [KindW-1:0]     kind_i,
  input  logic [DistW-1:0]     distance_i,
  input  logic [TagW-1:0]      tag_i,
  input  logic [RidxW-1:0]     read_index_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [CountOutW-1:0] entry_count_i,
  input  logic                 placed_i,
  input  logic [PosOutW-1:0]   position_i,
  input  logic                 read_valid_i,
  input  logic [DistW-1:0]     read_distance_i,
  input  logic [TagW-1:0]      read_tag_i,
  input  logic [CountOutW-1:0] within_radius_count_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [DistW-1:0]     cfg_radius_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [CountOutW-1:0] count;
    logic                 placed;
    logic [PosOutW-1:0]   pos;
    logic                 rvalid;
    logic [DistW-1:0]     rdist;
    logic [TagW-1:0]      rtag;
    logic [CountOutW-1:0] in_radius;
  } list_result_t;

  logic [DistW-1:0] slot_dist [DEPTH];
  logic [TagW-1:0]  slot_tag [DEPTH];
  int               held = 0;
  logic [DistW-1:0] radius_q = RadiusRst;
  list_result_t     result_q [$];
  list_result_t     want;
  list_result_t     got;

  function automatic list_result_t apply_item(kind_e k, logic [DistW-1:0] d,
                                              logic [TagW-1:0] t, logic [RidxW-1:0] ri);
    list_result_t r;
    int           last;
    int           p;
    int           n;
    bit           drop;
    r    = '0;
    last = 0;
    p    = 0;
    n    = 0;
    drop = 1'b0;
    case (k)
      KIND_CLEAR: begin
        held = 0;
      end
      KIND_INSERT: begin
        if (held >= DEPTH) begin
          if (d >= slot_dist[DEPTH-1]) drop = 1'b1;
          else last = DEPTH - 1;
        end else begin
          last = held;
          held = held + 1;
        end
        if (!drop) begin
          while (p < last && slot_dist[p] <= d) p++;
          for (int i = last; i > p; i--) begin
            slot_dist[i] = slot_dist[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_dist[p] = d;
          slot_tag[p]  = t;
          r.placed     = 1'b1;
          r.pos        = PosOutW'(p);
        end
      end
      KIND_READ: begin
        if (int'(ri) < held) begin
          r.rvalid = 1'b1;
          r.rdist  = slot_dist[ri];
          r.rtag   = slot_tag[ri];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < held; i++) begin
      if (slot_dist[i] <= radius_q) n++;
    end
    r.count     = CountOutW'(held);
    r.in_radius = CountOutW'(n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held     = 0;
      radius_q = RadiusRst;
      result_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          want          = result_q.pop_front();
          got.count     = entry_count_i;
          got.placed    = placed_i;
          got.pos       = position_i;
          got.rvalid    = read_valid_i;
          got.rdist     = read_distance_i;
          got.rtag      = read_tag_i;
          got.in_radius = within_radius_count_i;
          checked_o++;
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            fail_count_o++;
          end
          if (got.placed !== want.placed) begin
            $error("placed: expected %0d, got %0d", want.placed, got.placed);
            fail_count_o++;
          end
          if (got.pos !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, got.pos);
            fail_count_o++;
          end
          if (got.rvalid !== want.rvalid) begin
            $error("read_valid: expected %0d, got %0d", want.rvalid, got.rvalid);
            fail_count_o++;
          end
          if (got.rdist !== want.rdist) begin
            $error("read_distance: expected %0d, got %0d", want.rdist, got.rdist);
            fail_count_o++;
          end
          if (got.rtag !== want.rtag) begin
            $error("read_tag: expected %h, got %h", want.rtag, got.rtag);
            fail_count_o++;
          end
          if (got.in_radius !== want.in_radius) begin
            $error("within_radius_count: expected %0d, got %0d",
                   want.in_radius, got.in_radius);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) radius_q = cfg_radius_i;
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(apply_item(kind_e'(kind_i), distance_i, tag_i, read_index_i));
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// testbench top for the nearest-k sorted list: stimulus, idling and verdict
module tb;
  import nksl_pkg::*;

  localparam int RandomItems = 1300;

  logic               clk_i      = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  kind_e              in_kind    = KIND_NOP;
  logic [DistW-1:0]   in_dist    = '0;
  logic [TagW-1:0]    in_tag     = '0;
  logic [RidxW-1:0]   in_ridx    = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [CountOutW-1:0] entry_count;
  logic               placed;
  logic [PosOutW-1:0] position;
  logic               read_valid;
  logic [DistW-1:0]   read_distance;
  logic [TagW-1:0]    read_tag;
  logic [CountOutW-1:0] within_count;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [DistW-1:0]   cfg_radius = '0;

  int               fail_count;
  int               pending;
  int               checked;
  int               items_sent    = 0;
  int               radius_writes = 0;
  int               stall_left    = 0;
  bit               quiet         = 1'b0;
  logic [DistW-1:0] cur_radius    = RadiusRst;

  nearest_k_sorted_list #(.DEPTH(DepthDef)) uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .kind_i                (in_kind),
    .distance_i            (in_dist),
    .tag_i                 (in_tag),
    .read_index_i          (in_ridx),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .entry_count_o         (entry_count),
    .placed_o              (placed),
    .position_o            (position),
    .read_valid_o          (read_valid),
    .read_distance_o       (read_distance),
    .read_tag_o            (read_tag),
    .within_radius_count_o (within_count),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_radius_i          (cfg_radius)
  );

  nksl_list_checker #(.DEPTH(DepthDef)) u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .kind_i                (in_kind),
    .distance_i            (in_dist),
    .tag_i                 (in_tag),
    .read_index_i          (in_ridx),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .entry_count_i         (entry_count),
    .placed_i              (placed),
    .position_i            (position),
    .read_valid_i          (read_valid),
    .read_distance_i       (read_distance),
    .read_tag_i            (read_tag),
    .within_radius_count_i (within_count),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_radius_i          (cfg_radius),
    .fail_count_o          (fail_count),
    .pending_o             (pending),
    .checked_o             (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("nearest_k_sorted_list verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
    end
  end

  // entered and left at a falling edge
  task automatic send_item(kind_e k, logic [DistW-1:0] d, logic [TagW-1:0] t,
                           logic [RidxW-1:0] ri);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_dist  <= d;
    in_tag   <= t;
    in_ridx  <= ri;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_radius(logic [DistW-1:0] v);
    cfg_valid  <= 1'b1;
    cfg_radius <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cur_radius = v;
    radius_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DistW-1:0] pick_distance(int mode);
    int v;
    case (mode)
      0: return DistW'($urandom);
      1: return DistW'($urandom_range(0, 7));
      default: begin
        v = int'(cur_radius) + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return DistW'(v);
      end
    endcase
  endfunction

  initial begin
    int    phase;
    int    n_items;
    int    mode;
    int    r;
    kind_e k;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, extremes, ties, full list drop and evict, every index
    send_item(KIND_READ,   16'hffff, 32'hffffffff, 3'd0);
    send_item(KIND_NOP,    16'hffff, 32'hffffffff, 3'd7);
    send_item(KIND_INSERT, 16'hffff, 32'hffffffff, 3'd0);
    send_item(KIND_INSERT, 16'h0000, 32'h00000000, 3'd7);
    send_item(KIND_INSERT, RadiusRst, 32'h0000_0a01, 3'd0);
    send_item(KIND_INSERT, RadiusRst + 16'd1, 32'h0000_0a02, 3'd0);
    send_item(KIND_INSERT, RadiusRst, 32'h0000_0a03, 3'd0);
    send_item(KIND_INSERT, 16'h0000, 32'h0000_0a04, 3'd0);
    send_item(KIND_INSERT, 16'd100, 32'h0000_0a05, 3'd0);
    send_item(KIND_INSERT, 16'hffff, 32'h0000_0a06, 3'd0);
    send_item(KIND_INSERT, 16'hffff, 32'h0000_0a07, 3'd0);
    send_item(KIND_INSERT, 16'hfffe, 32'h0000_0a08, 3'd0);
    for (int i = 0; i < 8; i++) send_item(KIND_READ, '0, '0, RidxW'(i));
    send_item(KIND_CLEAR,  16'hffff, 32'hffffffff, 3'd7);
    send_item(KIND_READ,   16'h0000, 32'h00000000, 3'd0);
    send_item(KIND_NOP,    16'h0000, 32'h00000000, 3'd0);
    drain();

    phase = 0;
    while (items_sent < RandomItems + 23) begin
      drain();
      case (phase % 6)
        0: write_radius(16'h0000);
        1: write_radius(16'hffff);
        2: write_radius(RadiusRst);
        3: write_radius(DistW'($urandom));
        default: write_radius(DistW'($urandom_range(0, 2000)));
      endcase
      quiet   = ($urandom_range(0, 3) == 0);
      mode    = $urandom_range(0, 2);
      n_items = $urandom_range(40, 120);
      if ($urandom_range(0, 3) != 0) send_item(KIND_CLEAR, DistW'($urandom), $urandom, '0);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) k = KIND_INSERT;
        else if (r < 88) k = KIND_READ;
        else if (r < 95) k = KIND_NOP;
        else k = KIND_CLEAR;
        if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 2);
        send_item(k, pick_distance(mode), $urandom, RidxW'($urandom_range(0, 7)));
        if ($urandom_range(0, 99) < 3) drain();
      end
      phase++;
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("run covered %0d items over %0d radius settings, %0d result beats compared",
             items_sent, radius_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("nearest_k_sorted_list verification clean");
    end else begin
      $display("nearest_k_sorted_list verification failed");
    end
    $finish;
  end

endmodule
